/* rtl/srsg_pkg.sv */
// ----------------------------------------------------------------------------
// Stepper ramp step generator package
// Item types, register indexes, command codes and sequencer states of the
// generator, and the data widths that it shares with its divider.
// ----------------------------------------------------------------------------
package srsg_pkg;

  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned DIVISOR_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef struct packed {
    logic [31:0] timestamp;
    logic [1:0]  command;
  } srsg_in_t;

  typedef struct packed {
    logic               enable_pin;
    logic               direction_pin;
    logic               step_pin;
    logic [2:0]         microstep_pins;
    logic signed [15:0] velocity;
  } srsg_out_t;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COAST_RATE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_UNIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MICROSTEP_CODES = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_ENABLE    = 3'd6;

  localparam logic [1:0] CMD_COAST = 2'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ELAPSE,
    ST_LOCAL,
    ST_RDIV,
    ST_RCMP,
    ST_APPLY,
    ST_INDEX,
    ST_SSTART,
    ST_SDIV,
    ST_SCMP,
    ST_MIN1,
    ST_MIN2,
    ST_MIN3,
    ST_REBASE,
    ST_FINISH
  } srsg_state_t;

endpackage

/* rtl/srsg_div.sv */
// ----------------------------------------------------------------------------
// Stepper ramp step generator divider
// Restoring unsigned divider that retires two quotient bits per cycle.
// A zero divisor yields a quotient of all ones.
// ----------------------------------------------------------------------------
module srsg_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [srsg_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [srsg_pkg::DIVISOR_W-1:0]   divisor,
  output logic                             done,
  output logic [srsg_pkg::DIVIDEND_W-1:0]  quotient
);
  import srsg_pkg::*;

  localparam int unsigned STEPS = DIVIDEND_W / 2;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  rem_next;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVIDEND_W-1:0] quotient_next;
  logic [DIVISOR_W:0]    s1;
  logic [DIVISOR_W:0]    s2;
  logic [DIVISOR_W:0]    r1;
  logic [DIVISOR_W:0]    r2;
  logic                  ge1;
  logic                  ge2;

  always_comb begin
    s1            = {rem, quotient[DIVIDEND_W-1]};
    ge1           = s1 >= {1'b0, dsr};
    r1            = ge1 ? s1 - {1'b0, dsr} : s1;
    s2            = {r1[DIVISOR_W-1:0], quotient[DIVIDEND_W-2]};
    ge2           = s2 >= {1'b0, dsr};
    r2            = ge2 ? s2 - {1'b0, dsr} : s2;
    rem_next      = r2[DIVISOR_W-1:0];
    quotient_next = {quotient[DIVIDEND_W-3:0], ge1, ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      quotient <= quotient_next;
      rem      <= rem_next;
    end
  end

endmodule

/* rtl/stepper_ramp_step_generator_top.sv */
// An item whose velocity is updated also passes through the apply and index states,
// and at zero speed the step division is skipped.
// The ramp and step divisions run on the shared radix-4 divider.
// One item is worked on at a time; the result register frees the output side.
// Synchronous reset clears the timers, speed and pin levels and loads register defaults.
// ----------------------------------------------------------------------------
// Stepper ramp step generator
// Updates a local time base from timestamps, ramps a clamped signed velocity,
// selects the microstep level and toggles the step level once per interval.
// ----------------------------------------------------------------------------
module stepper_ramp_step_generator_top #(
  parameter logic [31:0] TIME_WRAP = 32'hFFFF_FFFF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  srsg_pkg::srsg_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output srsg_pkg::srsg_out_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [srsg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data
);
  import srsg_pkg::*;

  srsg_state_t state;
  srsg_state_t state_next;

  logic [14:0] max_speed;
  logic [15:0] accel_rate;
  logic [15:0] coast_rate;
  logic [31:0] time_scale;
  logic [11:0] speed_unit;
  logic [14:0] microstep_codes;
  logic        motor_enable;

  logic [31:0]        last_timestamp;
  logic [31:0]        local_time;
  logic [31:0]        next_ramp_time;
  logic [31:0]        next_step_time;
  logic signed [15:0] speed;
  logic               dir_level;
  logic               step_level;
  logic [2:0]         microstep_index;

  logic [31:0] ts_q;
  logic [1:0]  cmd_q;
  logic [31:0] elapsed;
  logic [31:0] interval;
  logic [31:0] low;
  logic [14:0] mag;

  logic                  div_start;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quotient;

  logic               out_free;
  logic               out_load;
  logic               time_hit;
  logic [31:0]        cmp_base;
  logic [32:0]        cmp_limit;
  logic signed [1:0]  delta;
  logic signed [16:0] speed_sum;
  logic signed [16:0] speed_lim;
  logic signed [16:0] speed_clamped;
  logic [15:0]        abs_speed;
  logic [14:0]        mag_new;
  logic [2:0]         index_new;
  logic [2:0]         code_sel;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  srsg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (time_scale),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed       <= 15'd1000;
      accel_rate      <= 16'd100;
      coast_rate      <= 16'd50;
      time_scale      <= 32'd1000000;
      speed_unit      <= 12'd64;
      microstep_codes <= '0;
      motor_enable    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_SPEED:       max_speed       <= cfg_data[14:0];
        REG_ACCEL_RATE:      accel_rate      <= cfg_data[15:0];
        REG_COAST_RATE:      coast_rate      <= cfg_data[15:0];
        REG_TIME_SCALE:      time_scale      <= cfg_data;
        REG_SPEED_UNIT:      speed_unit      <= cfg_data[11:0];
        REG_MICROSTEP_CODES: microstep_codes <= cfg_data[14:0];
        REG_MOTOR_ENABLE:    motor_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The ramp and step tests share one add and compare.
  always_comb begin
    cmp_base  = (state == ST_SCMP) ? next_step_time : next_ramp_time;
    cmp_limit = {1'b0, cmp_base} + {1'b0, interval};
    time_hit  = {1'b0, local_time} > cmp_limit;
  end

  always_comb begin
    if (cmd_q == CMD_COAST) begin
      if (speed > 16'sd0) begin
        delta = -2'sd1;
      end else if (speed < 16'sd0) begin
        delta = 2'sd1;
      end else begin
        delta = 2'sd0;
      end
    end else begin
      delta = $signed({1'b0, cmd_q[0]}) - $signed({1'b0, cmd_q[1]});
    end
    speed_sum = 17'(speed) + 17'(delta);
    speed_lim = $signed({2'b00, max_speed});
    if (speed_sum > speed_lim) begin
      speed_clamped = speed_lim;
    end else if (speed_sum < -speed_lim) begin
      speed_clamped = -speed_lim;
    end else begin
      speed_clamped = speed_sum;
    end
  end

  always_comb begin
    abs_speed = speed[15] ? 16'(-speed) : speed;
    mag_new   = abs_speed[14:0];
    if ({1'b0, mag_new} < {4'b0, speed_unit}) begin
      index_new = 3'd4;
    end else if ({1'b0, mag_new} < {3'b0, speed_unit, 1'b0}) begin
      index_new = 3'd3;
    end else if ({1'b0, mag_new} < {2'b0, speed_unit, 2'b0}) begin
      index_new = 3'd2;
    end else if ({1'b0, mag_new} < {1'b0, speed_unit, 3'b0}) begin
      index_new = 3'd1;
    end else begin
      index_new = 3'd0;
    end
  end

  always_comb begin
    case (microstep_index)
      3'd0:    code_sel = microstep_codes[2:0];
      3'd1:    code_sel = microstep_codes[5:3];
      3'd2:    code_sel = microstep_codes[8:6];
      3'd3:    code_sel = microstep_codes[11:9];
      3'd4:    code_sel = microstep_codes[14:12];
      default: code_sel = 3'd0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_ELAPSE;
      ST_ELAPSE: state_next = ST_LOCAL;
      ST_LOCAL:  state_next = ST_RDIV;
      ST_RDIV:   if (div_done) state_next = ST_RCMP;
      ST_RCMP:   state_next = time_hit ? ST_APPLY : ST_SSTART;
      ST_APPLY:  state_next = ST_INDEX;
      ST_INDEX:  state_next = ST_SSTART;
      ST_SSTART: state_next = (speed == 16'sd0) ? ST_MIN1 : ST_SDIV;
      ST_SDIV:   if (div_done) state_next = ST_SCMP;
      ST_SCMP:   state_next = ST_MIN1;
      ST_MIN1:   state_next = ST_MIN2;
      ST_MIN2:   state_next = ST_MIN3;
      ST_MIN3:   state_next = ST_REBASE;
      ST_REBASE: state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == ST_IDLE);
    div_start   = 1'b0;
    div_divisor = {1'b0, mag};
    out_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        div_start   = in_valid;
        div_divisor = (in_data.command == CMD_COAST) ? coast_rate : accel_rate;
      end
      ST_SSTART: begin
        div_start = (speed != 16'sd0);
      end
      ST_FINISH: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_timestamp  <= '0;
      local_time      <= '0;
      next_ramp_time  <= '0;
      next_step_time  <= '0;
      speed           <= '0;
      dir_level       <= 1'b0;
      step_level      <= 1'b0;
      microstep_index <= '0;
    end else begin
      case (state)
        ST_ELAPSE: last_timestamp <= ts_q;
        ST_LOCAL:  local_time <= local_time + elapsed;
        ST_RCMP: begin
          if (time_hit) next_ramp_time <= next_ramp_time + interval;
        end
        ST_APPLY: begin
          speed     <= speed_clamped[15:0];
          dir_level <= speed_clamped[16];
        end
        ST_INDEX:  microstep_index <= index_new;
        ST_SSTART: begin
          if (speed == 16'sd0) next_step_time <= local_time;
        end
        ST_SCMP: begin
          if (time_hit) begin
            next_step_time <= next_step_time + interval;
            step_level     <= ~step_level;
          end
        end
        ST_REBASE: begin
          next_ramp_time <= next_ramp_time - low;
          next_step_time <= next_step_time - low;
          local_time     <= local_time - low;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ts_q  <= in_data.timestamp;
          cmd_q <= in_data.command;
        end
      end
      ST_ELAPSE: begin
        elapsed <= ts_q - last_timestamp + ((last_timestamp > ts_q) ? TIME_WRAP : 32'd0);
      end
      ST_RDIV: begin
        if (div_done) interval <= div_quotient;
      end
      ST_INDEX: mag <= mag_new;
      ST_SDIV: begin
        if (div_done) interval <= div_quotient >> microstep_index;
      end
      ST_MIN1: low <= (next_ramp_time < TIME_WRAP) ? next_ramp_time : TIME_WRAP;
      ST_MIN2: low <= (next_step_time < low) ? next_step_time : low;
      ST_MIN3: low <= (local_time < low) ? local_time : low;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.enable_pin     <= motor_enable;
      out_data.direction_pin  <= dir_level;
      out_data.step_pin       <= step_level;
      out_data.microstep_pins <= code_sel;
      out_data.velocity       <= speed;
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper ramp step generator testbench
// Drives timestamp and command items through the generator, predicts every
// result from its own copy of the timers, speed and pin levels, and compares
// each result field by field. Directed items cover reset values, timestamp
// wrap, the speed limit and zero rate divisors; random motion sequences then
// run under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import srsg_pkg::*;

  localparam logic [31:0] WRAP_POINT = 32'hFFFF_FFFF;
  localparam logic [1:0] CMD_FORWARD = 2'd1;
  localparam logic [1:0] CMD_BACKWARD = 2'd2;
  localparam logic [1:0] CMD_HOLD = 2'd3;
  localparam logic [14:0] INDEX_CODES = 15'h4688;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned ITEMS_PER_PHASE = 270;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  srsg_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  srsg_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [14:0] max_speed_r = 15'd1000;
  logic [15:0] accel_rate_r = 16'd100;
  logic [15:0] coast_rate_r = 16'd50;
  logic [31:0] time_scale_r = 32'd1000000;
  logic [11:0] speed_unit_r = 12'd64;
  logic [14:0] ustep_codes_r = 15'd0;
  logic motor_en_r = 1'b0;

  logic [31:0] last_ts = '0;
  logic [31:0] local_clk = '0;
  logic [31:0] ramp_due = '0;
  logic [31:0] step_due = '0;
  int speed = 0;
  logic dir_lvl = 1'b0;
  logic step_lvl = 1'b0;
  logic [2:0] ustep_idx = '0;

  srsg_out_t pending_pins[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;

  stepper_ramp_step_generator_top #(
    .TIME_WRAP(WRAP_POINT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5ns clk = ~clk;

  function automatic logic [31:0] rate_interval(input logic [31:0] num, input logic [15:0] rate);
    return (rate == 16'd0) ? 32'hFFFF_FFFF : num / rate;
  endfunction

  function automatic logic [31:0] step_interval();
    logic [31:0] mag;
    mag = (speed < 0) ? -speed : speed;
    return (time_scale_r / mag) >> ustep_idx;
  endfunction

  task automatic advance_motor(input srsg_in_t item);
    logic [31:0] elapsed;
    logic [31:0] span;
    logic [31:0] low;
    logic [31:0] mag;
    logic [31:0] unit;
    logic [14:0] shifted;
    int lim;
    int delta;
    srsg_out_t res;
    if (last_ts > item.timestamp) begin
      elapsed = WRAP_POINT - last_ts + item.timestamp;
    end else begin
      elapsed = item.timestamp - last_ts;
    end
    last_ts = item.timestamp;
    local_clk = local_clk + elapsed;

    span = rate_interval(time_scale_r,
                         (item.command == CMD_COAST) ? coast_rate_r : accel_rate_r);
    if ({1'b0, local_clk} > {1'b0, ramp_due} + {1'b0, span}) begin
      ramp_due = ramp_due + span;
      if (item.command == CMD_COAST) begin
        delta = (speed > 0) ? -1 : ((speed < 0) ? 1 : 0);
      end else begin
        delta = (item.command == CMD_FORWARD) ? 1 : ((item.command == CMD_BACKWARD) ? -1 : 0);
      end
      lim = int'(max_speed_r);
      speed = speed + delta;
      if (speed > lim) speed = lim;
      if (speed < -lim) speed = -lim;
      dir_lvl = (speed < 0);
      mag = (speed < 0) ? -speed : speed;
      unit = 32'(speed_unit_r);
      ustep_idx = 3'd0;
      if (mag < unit * 8) ustep_idx = 3'd1;
      if (mag < unit * 4) ustep_idx = 3'd2;
      if (mag < unit * 2) ustep_idx = 3'd3;
      if (mag < unit) ustep_idx = 3'd4;
    end

    if (speed == 0) begin
      step_due = local_clk;
    end else begin
      span = step_interval();
      if ({1'b0, local_clk} > {1'b0, step_due} + {1'b0, span}) begin
        step_due = step_due + span;
        step_lvl = ~step_lvl;
      end
    end

    low = WRAP_POINT;
    if (low > ramp_due) low = ramp_due;
    if (low > step_due) low = step_due;
    if (low > local_clk) low = local_clk;
    ramp_due = ramp_due - low;
    step_due = step_due - low;
    local_clk = local_clk - low;

    shifted = ustep_codes_r >> (3 * ustep_idx);
    res.enable_pin = motor_en_r;
    res.direction_pin = dir_lvl;
    res.step_pin = step_lvl;
    res.microstep_pins = (ustep_idx <= 3'd4) ? shifted[2:0] : 3'd0;
    res.velocity = 16'(speed);
    pending_pins.push_back(res);
  endtask

  task automatic send_step(input logic [31:0] ts, input logic [1:0] cmd);
    srsg_in_t item;
    item.timestamp = ts;
    item.command = cmd;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    advance_motor(item);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAX_SPEED: max_speed_r = value[14:0];
      REG_ACCEL_RATE: accel_rate_r = value[15:0];
      REG_COAST_RATE: coast_rate_r = value[15:0];
      REG_TIME_SCALE: time_scale_r = value;
      REG_SPEED_UNIT: speed_unit_r = value[11:0];
      REG_MICROSTEP_CODES: ustep_codes_r = value[14:0];
      REG_MOTOR_ENABLE: motor_en_r = value[0];
      default: ;
    endcase
  endtask

  task automatic program_registers(input logic [31:0] max_spd, input logic [31:0] accel,
                                   input logic [31:0] coast, input logic [31:0] scale,
                                   input logic [31:0] unit, input logic [31:0] codes,
                                   input logic [31:0] enable);
    wait_drained();
    write_reg(REG_MAX_SPEED, max_spd);
    write_reg(REG_ACCEL_RATE, accel);
    write_reg(REG_COAST_RATE, coast);
    write_reg(REG_TIME_SCALE, scale);
    write_reg(REG_SPEED_UNIT, unit);
    write_reg(REG_MICROSTEP_CODES, codes);
    write_reg(REG_MOTOR_ENABLE, enable);
    cfg_valid <= 1'b0;
  endtask

  task automatic drive_motion(input int unsigned count);
    logic [31:0] ts;
    logic [31:0] base;
    logic [31:0] reach;
    logic [1:0] cmd;
    int unsigned run;
    int unsigned sent;
    int unsigned roll;
    bit noisy;
    ts = last_ts;
    sent = 0;
    while (sent < count) begin
      noisy = ($urandom_range(99) >= 85);
      cmd = 2'($urandom_range(3));
      run = (cmd == CMD_HOLD) ? $urandom_range(15, 3) : $urandom_range(60, 10);
      if (noisy) run = $urandom_range(8, 1);
      repeat (run) begin
        if (noisy) cmd = 2'($urandom_range(3));
        base = rate_interval(time_scale_r, (cmd == CMD_COAST) ? coast_rate_r : accel_rate_r);
        if (speed != 0 && $urandom_range(1) == 1) base = step_interval();
        reach = (base > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : base << 1;
        roll = $urandom_range(99);
        if (roll < 8) begin
          ts = ts;
        end else if (roll < 70) begin
          ts = ts + $urandom_range(reach);
        end else if (roll < 85) begin
          ts = ts + $urandom_range(base >> 2);
        end else if (roll < 96) begin
          ts = ts + base + $urandom_range(base);
        end else begin
          ts = $urandom;
        end
        send_step(ts, cmd);
        sent++;
      end
    end
  endtask

  task automatic test_reset_values();
    send_step(32'd0, CMD_COAST);
    send_step(32'd50000, CMD_FORWARD);
    send_step(32'd50001, CMD_FORWARD);
    send_step(32'd120000, CMD_FORWARD);
    send_step(32'd120010, CMD_HOLD);
    send_step(32'd200000, CMD_BACKWARD);
    send_step(32'd200005, CMD_BACKWARD);
    send_step(32'hFFFF_FFF0, CMD_COAST);
    send_step(32'h0000_0005, CMD_COAST);
    send_step(32'hFFFF_FFFF, CMD_HOLD);
    send_step(32'h0000_0000, CMD_FORWARD);
  endtask

  task automatic test_speed_limit();
    program_registers(3, 1, 1, 1000, 1, 32'(INDEX_CODES), 1);
    repeat (5) send_step(last_ts + 32'd5000, CMD_FORWARD);
    program_registers(1, 1, 1, 1000, 1, 32'(INDEX_CODES), 1);
    send_step(last_ts, CMD_HOLD);
    send_step(last_ts + 32'd3000, CMD_BACKWARD);
    program_registers(0, 1, 1, 1000, 1, 32'(INDEX_CODES), 1);
    send_step(last_ts + 32'd3000, CMD_FORWARD);
    send_step(last_ts + 32'd3000, CMD_BACKWARD);
  endtask

  task automatic test_zero_rates();
    program_registers(1000, 0, 0, 1000000, 64, $urandom_range(32'h7FFF), 1);
    send_step(last_ts + 32'd1000000, CMD_FORWARD);
    send_step(last_ts + 32'h7FFF_FFFF, CMD_COAST);
    send_step(last_ts + 32'h7FFF_FFFF, CMD_HOLD);
  endtask

  task automatic test_random_traffic();
    in_idle_pct = 0;
    out_stall_pct = 0;
    program_registers($urandom_range(300, 20), $urandom_range(2000, 50),
                      $urandom_range(2000, 50), $urandom_range(2000000, 100000),
                      $urandom_range(16, 1), $urandom_range(32'h7FFF), 1);
    drive_motion(ITEMS_PER_PHASE);

    in_idle_pct = 88;
    program_registers(32767, 65535, 65535, 32'hFFFF_FFFF, 4095, 0, 0);
    drive_motion(ITEMS_PER_PHASE);

    in_idle_pct = 0;
    out_stall_pct = 88;
    program_registers(1, 1, 1, 1, 1, 32'h7FFF, 1);
    drive_motion(ITEMS_PER_PHASE);

    in_idle_pct = 27;
    out_stall_pct = 27;
    program_registers($urandom_range(600, 1), $urandom_range(3000, 1),
                      $urandom_range(3000, 1), $urandom_range(5000000, 1000),
                      $urandom_range(40, 1), $urandom_range(32'h7FFF),
                      $urandom_range(1));
    drive_motion(ITEMS_PER_PHASE);
  endtask

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on %s: expected %0h, actual %0h", fname, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    srsg_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result with no pending item: velocity %0h", out_data.velocity);
        end
      end else begin
        want = pending_pins.pop_front();
        check_field("enable_pin", 16'(want.enable_pin), 16'(out_data.enable_pin));
        check_field("direction_pin", 16'(want.direction_pin), 16'(out_data.direction_pin));
        check_field("step_pin", 16'(want.step_pin), 16'(out_data.step_pin));
        check_field("microstep_pins", 16'(want.microstep_pins), 16'(out_data.microstep_pins));
        check_field("velocity", want.velocity, out_data.velocity);
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_speed_limit();
    test_zero_rates();
    test_random_traffic();
    wait_drained();
    repeat (56) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* stepper_ramp_step_generator_top.f */
rtl/srsg_pkg.sv
rtl/srsg_div.sv
rtl/stepper_ramp_step_generator_top.sv
tb/tb_top.sv
